### hdl/lr4_pkg.sv
// Shared types, constants and the step program for the Lorenz RK4 integrator.
// The word format, register map and micro-op decode are defined here.
// It has no dependencies. The controller, datapath and top level import it.
package lr4_pkg;

	// Fixed-point word format.
	localparam int WORD_BITS = 48;
	localparam int FRAC_BITS = 32;
	localparam int HALF_BITS = (WORD_BITS + 1) / 2;
	localparam int MAG_BITS  = 2 * HALF_BITS;
	localparam int PROD_BITS = 2 * MAG_BITS;
	localparam int QR_BITS   = PROD_BITS - FRAC_BITS + 1;
	localparam int CNT_BITS  = 32;
	localparam int H_BITS    = 33;
	localparam int H2_BITS   = 32;
	localparam int H6_BITS   = 30;
	localparam int IDX_BITS  = 3;

	typedef logic signed [WORD_BITS-1:0] word_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam word_t WORD_ONE = word_t'(1) <<< FRAC_BITS;

	// Register reset values.
	localparam word_t SIGMA_RST = word_t'(64'sd42949672960);
	localparam word_t RHO_RST   = word_t'(64'sd120259084288);
	localparam word_t BETA_RST  = word_t'(64'sd11453246123);
	localparam logic [H_BITS-1:0]  H_RST  = H_BITS'(42949673);
	localparam logic [H2_BITS-1:0] H2_RST = H2_BITS'(21474836);
	localparam logic [H6_BITS-1:0] H6_RST = H6_BITS'(7158279);

	// Configuration register indexes.
	typedef enum logic [IDX_BITS-1:0] {
		CFG_SIGMA,
		CFG_RHO,
		CFG_BETA,
		CFG_STEP,
		CFG_HALF,
		CFG_SIXTH
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EXEC,
		ST_MUL,
		ST_WB,
		ST_DONE
	} state_t;

	// Operand address space: bit 4 clear selects a flop register, set selects scratch.
	typedef logic [4:0] addr_t;
	localparam addr_t A_X   = 5'd0;
	localparam addr_t A_Y   = 5'd1;
	localparam addr_t A_Z   = 5'd2;
	localparam addr_t A_SG  = 5'd3;
	localparam addr_t A_RH  = 5'd4;
	localparam addr_t A_BT  = 5'd5;
	localparam addr_t A_H   = 5'd6;
	localparam addr_t A_H2  = 5'd7;
	localparam addr_t A_H6  = 5'd8;
	localparam addr_t A_CX  = 5'd16;
	localparam addr_t A_CY  = 5'd17;
	localparam addr_t A_CZ  = 5'd18;
	localparam addr_t A_K1X = 5'd19;
	localparam addr_t A_K2X = 5'd22;
	localparam addr_t A_K3X = 5'd25;
	localparam addr_t A_K4X = 5'd28;
	localparam addr_t A_T   = 5'd31;

	typedef struct packed {
		op_t   op;
		addr_t src_a;
		addr_t src_b;
		addr_t dst;
		logic  last;
	} instr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  restart;
		logic  clear;
		logic  rd;
		logic  exec;
		logic  wb;
		logic  step_done;
		logic  out_load;
		op_t   op;
		addr_t src_a;
		addr_t src_b;
		addr_t dst;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
	} status_t;

	function automatic instr_t mk(op_t op, addr_t a, addr_t b, addr_t d);
		instr_t r;
		r.op    = op;
		r.src_a = a;
		r.src_b = b;
		r.dst   = d;
		r.last  = 1'b0;
		return r;
	endfunction

	// Step program. Blocks 0..3 evaluate k1..k4 and, except the last, form the
	// next evaluation point. Block 4 combines the slopes, one axis at a time.
	function automatic instr_t decode(logic [2:0] blk, logic [1:0] ax, logic [3:0] sub);
		addr_t  px, py, pz, kx, ky, kz, hs, k1, k2, k3, k4, s;
		instr_t r;
		px = (blk == 3'd0) ? A_X : A_CX;
		py = (blk == 3'd0) ? A_Y : A_CY;
		pz = (blk == 3'd0) ? A_Z : A_CZ;
		kx = addr_t'(int'(A_K1X) + 3 * int'(blk));
		ky = addr_t'(kx + 5'd1);
		kz = addr_t'(kx + 5'd2);
		hs = (blk == 3'd2) ? A_H : A_H2;
		k1 = addr_t'(A_K1X + addr_t'(ax));
		k2 = addr_t'(A_K2X + addr_t'(ax));
		k3 = addr_t'(A_K3X + addr_t'(ax));
		k4 = addr_t'(A_K4X + addr_t'(ax));
		s  = addr_t'(A_X + addr_t'(ax));
		r  = mk(OP_ADD, A_T, A_T, A_T);
		if (blk == 3'd4) begin
			case (sub)
				4'd0: r = mk(OP_ADD, k2, k2, k2);
				4'd1: r = mk(OP_ADD, k1, k2, k2);
				4'd2: r = mk(OP_ADD, k3, k3, k3);
				4'd3: r = mk(OP_ADD, k2, k3, k2);
				4'd4: r = mk(OP_ADD, k2, k4, k2);
				4'd5: r = mk(OP_MUL, A_H6, k2, k2);
				4'd6: begin
					r = mk(OP_ADD, s, k2, s);
					r.last = (ax == 2'd2);
				end
				default: r = mk(OP_ADD, A_T, A_T, A_T);
			endcase
		end else begin
			case (sub)
				4'd0:  r = mk(OP_SUB, py, px, A_T);
				4'd1:  r = mk(OP_MUL, A_SG, A_T, kx);
				4'd2:  r = mk(OP_SUB, A_RH, pz, A_T);
				4'd3:  r = mk(OP_MUL, px, A_T, A_T);
				4'd4:  r = mk(OP_SUB, A_T, py, ky);
				4'd5:  r = mk(OP_MUL, px, py, A_T);
				4'd6:  r = mk(OP_MUL, A_BT, pz, kz);
				4'd7:  r = mk(OP_SUB, A_T, kz, kz);
				4'd8:  r = mk(OP_MUL, hs, kx, A_T);
				4'd9:  r = mk(OP_ADD, A_X, A_T, A_CX);
				4'd10: r = mk(OP_MUL, hs, ky, A_T);
				4'd11: r = mk(OP_ADD, A_Y, A_T, A_CY);
				4'd12: r = mk(OP_MUL, hs, kz, A_T);
				4'd13: r = mk(OP_ADD, A_Z, A_T, A_CZ);
				default: r = mk(OP_ADD, A_T, A_T, A_T);
			endcase
		end
		return r;
	endfunction

endpackage

### hdl/lr4_controller.sv
// Sequencer for the Lorenz RK4 integrator: input and output handshakes and
// the walk through the step program. Depends on lr4_pkg.
module lr4_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_cmd,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lr4_pkg::status_t status,
	output lr4_pkg::cmd_t    cmd
);
	import lr4_pkg::*;

	state_t     state_q, state_nxt;
	logic [2:0] blk_q;
	logic [1:0] ax_q;
	logic [3:0] sub_q;
	logic       out_valid_q;
	instr_t     instr;
	logic       accept;
	logic       load;

	assign instr  = decode(blk_q, ax_q, sub_q);
	assign accept = (state_q == ST_IDLE) && in_valid;
	assign load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = in_cmd ? ST_DONE : ST_READ;
				end
			end
			ST_READ: state_nxt = ST_EXEC;
			ST_EXEC: state_nxt = (instr.op == OP_MUL) ? ST_MUL : ST_WB;
			ST_MUL: begin
				if (status.mul_done) begin
					state_nxt = ST_WB;
				end
			end
			ST_WB:   state_nxt = instr.last ? ST_DONE : ST_READ;
			ST_DONE: begin
				if (load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs.
	always_comb begin
		cmd.restart   = accept && in_cmd;
		cmd.clear     = accept && !in_cmd;
		cmd.rd        = (state_q == ST_READ);
		cmd.exec      = (state_q == ST_EXEC);
		cmd.wb        = (state_q == ST_WB);
		cmd.step_done = (state_q == ST_WB) && instr.last;
		cmd.out_load  = load;
		cmd.op        = instr.op;
		cmd.src_a     = instr.src_a;
		cmd.src_b     = instr.src_b;
		cmd.dst       = instr.dst;
		in_ready      = (state_q == ST_IDLE);
		out_valid     = out_valid_q;
	end

	// State, program position and output-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			blk_q       <= '0;
			ax_q        <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.clear) begin
				blk_q <= '0;
				ax_q  <= '0;
				sub_q <= '0;
			end else if (cmd.wb && !instr.last) begin
				if (blk_q == 3'd4) begin
					if (sub_q == 4'd6) begin
						sub_q <= '0;
						ax_q  <= ax_q + 2'd1;
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end else if (sub_q == ((blk_q == 3'd3) ? 4'd7 : 4'd13)) begin
					sub_q <= '0;
					blk_q <= blk_q + 3'd1;
				end else begin
					sub_q <= sub_q + 4'd1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/lr4_datapath.sv
// Datapath of the Lorenz RK4 integrator: state and coefficient registers,
// scratch memory, saturating adder and a multi-cycle rounding multiplier.
// Depends on lr4_pkg; driven by lr4_controller.
module lr4_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lr4_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [lr4_pkg::WORD_BITS-1:0]    cfg_wdata,
	input  lr4_pkg::word_t                   init_x,
	input  lr4_pkg::word_t                   init_y,
	input  lr4_pkg::word_t                   init_z,
	input  lr4_pkg::cmd_t                    cmd,
	output lr4_pkg::status_t                 status,
	output logic [lr4_pkg::CNT_BITS-1:0]     step_index,
	output lr4_pkg::word_t                   pos_x,
	output lr4_pkg::word_t                   pos_y,
	output lr4_pkg::word_t                   pos_z,
	output logic                             saturated
);
	import lr4_pkg::*;

	word_t               x_q, y_q, z_q, sigma_q, rho_q, beta_q;
	logic [H_BITS-1:0]   h_q;
	logic [H2_BITS-1:0]  h2_q;
	logic [H6_BITS-1:0]  h6_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                sat_q;

	word_t mem_q [16];
	word_t rda_mem_q, rdb_mem_q, rda_arch_q, rdb_arch_q;
	logic  rda_sel_q, rdb_sel_q;
	word_t arch_a, arch_b, opa, opb;

	word_t res_q;
	logic  res_sat_q;

	logic [MAG_BITS-1:0]  ma_q, mb_q;
	logic                 neg_q, mul_busy_q, rnd_q;
	logic [1:0]           mcnt_q;
	logic [PROD_BITS-1:0] acc_q;

	logic [CNT_BITS-1:0] step_index_q;
	word_t               pos_x_q, pos_y_q, pos_z_q;
	logic                saturated_q;

	function automatic word_t arch_read(addr_t a, word_t x, word_t y, word_t z,
			word_t sg, word_t rh, word_t bt, logic [H_BITS-1:0] h,
			logic [H2_BITS-1:0] h2, logic [H6_BITS-1:0] h6);
		word_t v;
		case (a)
			A_X:  v = x;
			A_Y:  v = y;
			A_Z:  v = z;
			A_SG: v = sg;
			A_RH: v = rh;
			A_BT: v = bt;
			A_H:  v = {{(WORD_BITS-H_BITS){1'b0}}, h};
			A_H2: v = {{(WORD_BITS-H2_BITS){1'b0}}, h2};
			A_H6: v = {{(WORD_BITS-H6_BITS){1'b0}}, h6};
			default: v = '0;
		endcase
		return v;
	endfunction

	// Operand selection from the flop registers and the registered operand reads.
	always_comb begin
		arch_a = arch_read(cmd.src_a, x_q, y_q, z_q, sigma_q, rho_q, beta_q, h_q, h2_q, h6_q);
		arch_b = arch_read(cmd.src_b, x_q, y_q, z_q, sigma_q, rho_q, beta_q, h_q, h2_q, h6_q);
		opa    = rda_sel_q ? rda_mem_q : rda_arch_q;
		opb    = rdb_sel_q ? rdb_mem_q : rdb_arch_q;
	end

	// Operand read and scratch write-back.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rda_mem_q  <= mem_q[cmd.src_a[3:0]];
			rdb_mem_q  <= mem_q[cmd.src_b[3:0]];
			rda_arch_q <= arch_a;
			rdb_arch_q <= arch_b;
			rda_sel_q  <= cmd.src_a[4];
			rdb_sel_q  <= cmd.src_b[4];
		end
		if (cmd.wb && cmd.dst[4]) begin
			mem_q[cmd.dst[3:0]] <= res_q;
		end
	end

	// Saturating add and subtract.
	logic [WORD_BITS:0] sum;
	logic               sum_ovf;
	always_comb begin
		if (cmd.op == OP_SUB) begin
			sum = {opa[WORD_BITS-1], opa} - {opb[WORD_BITS-1], opb};
		end else begin
			sum = {opa[WORD_BITS-1], opa} + {opb[WORD_BITS-1], opb};
		end
		sum_ovf = sum[WORD_BITS] != sum[WORD_BITS-1];
	end

	// Multiplier: one half-by-half partial product a cycle, then rounding.
	logic [HALF_BITS-1:0]   pa, pb;
	logic [2*HALF_BITS-1:0] part;
	logic [PROD_BITS-1:0]   part_ext;
	logic [QR_BITS-2:0]     q;
	logic [FRAC_BITS-1:0]   rem;
	logic                   round_up;
	logic [QR_BITS-1:0]     qr, lim;
	logic [MAG_BITS-1:0]    mag_a, mag_b;
	always_comb begin
		mag_a    = MAG_BITS'(opa[WORD_BITS-1] ? -opa : opa);
		mag_b    = MAG_BITS'(opb[WORD_BITS-1] ? -opb : opb);
		pa       = mcnt_q[1] ? ma_q[MAG_BITS-1:HALF_BITS] : ma_q[HALF_BITS-1:0];
		pb       = mcnt_q[0] ? mb_q[MAG_BITS-1:HALF_BITS] : mb_q[HALF_BITS-1:0];
		part     = pa * pb;
		part_ext = PROD_BITS'(part) << (HALF_BITS * (int'(mcnt_q[1]) + int'(mcnt_q[0])));
		q        = acc_q[PROD_BITS-1:FRAC_BITS];
		rem      = acc_q[FRAC_BITS-1:0];
		round_up = (rem > {1'b1, {(FRAC_BITS-1){1'b0}}})
			|| ((rem == {1'b1, {(FRAC_BITS-1){1'b0}}}) && q[0]);
		qr       = {1'b0, q} + QR_BITS'(round_up);
		lim      = {{(QR_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}}
			+ QR_BITS'(neg_q);
		status.mul_done = mul_busy_q && rnd_q;
	end

	// Execute: add/sub, or accumulate and round a multiply.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			rnd_q      <= 1'b0;
			mcnt_q     <= '0;
			res_q      <= '0;
			res_sat_q  <= 1'b0;
			neg_q      <= 1'b0;
			ma_q       <= '0;
			mb_q       <= '0;
			acc_q      <= '0;
		end else begin
			if (cmd.exec) begin
				case (cmd.op)
					OP_ADD, OP_SUB: begin
						res_sat_q <= sum_ovf;
						res_q     <= sum_ovf ? (sum[WORD_BITS] ? WORD_MIN : WORD_MAX)
							: sum[WORD_BITS-1:0];
					end
					OP_MUL: begin
						neg_q      <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
						ma_q       <= mag_a;
						mb_q       <= mag_b;
						acc_q      <= '0;
						mcnt_q     <= '0;
						rnd_q      <= 1'b0;
						mul_busy_q <= 1'b1;
					end
					default: ;
				endcase
			end else if (mul_busy_q && !rnd_q) begin
				acc_q  <= acc_q + part_ext;
				mcnt_q <= mcnt_q + 2'd1;
				if (mcnt_q == 2'd3) begin
					rnd_q <= 1'b1;
				end
			end else if (mul_busy_q) begin
				mul_busy_q <= 1'b0;
				rnd_q      <= 1'b0;
				res_sat_q  <= qr > lim;
				if (qr > lim) begin
					res_q <= neg_q ? WORD_MIN : WORD_MAX;
				end else if (neg_q) begin
					res_q <= -word_t'(qr[WORD_BITS-1:0]);
				end else begin
					res_q <= qr[WORD_BITS-1:0];
				end
			end
		end
	end

	// Architectural state, coefficients, step counter and saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= WORD_ONE;
			z_q     <= WORD_ONE;
			sigma_q <= SIGMA_RST;
			rho_q   <= RHO_RST;
			beta_q  <= BETA_RST;
			h_q     <= H_RST;
			h2_q    <= H2_RST;
			h6_q    <= H6_RST;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIGMA: sigma_q <= cfg_wdata;
					CFG_RHO:   rho_q   <= cfg_wdata;
					CFG_BETA:  beta_q  <= cfg_wdata;
					CFG_STEP:  h_q     <= cfg_wdata[H_BITS-1:0];
					CFG_HALF:  h2_q    <= cfg_wdata[H2_BITS-1:0];
					CFG_SIXTH: h6_q    <= cfg_wdata[H6_BITS-1:0];
					default: ;
				endcase
			end
			if (cmd.restart) begin
				x_q   <= init_x;
				y_q   <= init_y;
				z_q   <= init_z;
				cnt_q <= '0;
				sat_q <= 1'b0;
			end else if (cmd.clear) begin
				sat_q <= 1'b0;
			end else if (cmd.wb) begin
				sat_q <= sat_q | res_sat_q;
				if (!cmd.dst[4]) begin
					case (cmd.dst)
						A_X: x_q <= res_q;
						A_Y: y_q <= res_q;
						A_Z: z_q <= res_q;
						default: ;
					endcase
				end
				if (cmd.step_done) begin
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			step_index_q <= cnt_q;
			pos_x_q      <= x_q;
			pos_y_q      <= y_q;
			pos_z_q      <= z_q;
			saturated_q  <= sat_q;
		end
	end

	assign step_index = step_index_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign pos_z      = pos_z_q;
	assign saturated  = saturated_q;

endmodule

### hdl/lorenz_rk4_integrator.sv
// Lorenz RK4 integrator. Restart beats load the state and report step 0.
// Step beats run 71 micro-ops in sequence, adds and multiplies, the
// multiplies on the single half-width multiplier.
// One beat is in flight; the result register lets the next beat be taken.
// Asynchronous reset: x = 0, y = z = 1.0, counter 0, default coefficients.
module lorenz_rk4_integrator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lr4_pkg::IDX_BITS-1:0]  cfg_index,
	input  logic [lr4_pkg::WORD_BITS-1:0] cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [143:0]                  s_axis_tdata,  // init_x, init_y, init_z
	input  logic [0:0]                    s_axis_tuser,  // cmd
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [175:0]                  m_axis_tdata,  // step_index, pos_x, pos_y, pos_z
	output logic [0:0]                    m_axis_tuser   // saturated
);
	import lr4_pkg::*;

	cmd_t    cmd;
	status_t status;
	word_t   pos_x, pos_y, pos_z;
	logic [CNT_BITS-1:0] step_index;
	logic    saturated;

	lr4_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	lr4_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.init_x     (s_axis_tdata[47:0]),
		.init_y     (s_axis_tdata[95:48]),
		.init_z     (s_axis_tdata[143:96]),
		.cmd        (cmd),
		.status     (status),
		.step_index (step_index),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.saturated  (saturated)
	);

	assign m_axis_tdata = {pos_z, pos_y, pos_x, step_index};
	assign m_axis_tuser = saturated;

endmodule

### hdl/lr4_checker.sv
// Port-level checks for the Lorenz RK4 integrator, bound to the top level.
// Depends only on the top-level ports.
module lr4_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [2:0]   cfg_index,
	input logic [47:0]  cfg_wdata,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [143:0] s_axis_tdata,
	input logic [0:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [175:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	// A held result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result payload changed while stalled");

	// Only one beat is worked on at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while busy");

	// A restart into an empty output reports step 0 with the loaded x once the done state has loaded the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid |=> ##1
		(m_axis_tvalid && m_axis_tdata[31:0] == 32'd0 && !m_axis_tuser[0]
		&& m_axis_tdata[79:32] == $past(s_axis_tdata[47:0], 2)))
		else $error("restart result wrong");

	// A step beat does not produce its result as soon as a restart beat does.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] |=> ##1 !$rose(m_axis_tvalid))
		else $error("step result appeared too early");

	// Registers are written only while the block is idle, with a known index and value.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_axis_tready && !m_axis_tvalid && !$isunknown({cfg_index, cfg_wdata}))
		else $error("register write while busy");

endmodule

bind lorenz_rk4_integrator lr4_checker u_lr4_checker (.*);

### bench/lorenz_checker.sv
// Checker for the Lorenz RK4 integrator: watches the configuration port and both streams,
// predicts every result in fixed point and compares it field by field.
// Depends on lr4_pkg for the word type, the reset coefficients and register indexes.
module lorenz_checker
	import lr4_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [IDX_BITS-1:0]  cfg_index,
	input  logic [WORD_BITS-1:0] cfg_wdata,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [143:0]         s_axis_tdata,  // init_x, init_y, init_z
	input  logic [0:0]           s_axis_tuser,  // cmd
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [175:0]         m_axis_tdata,  // step_index, pos_x, pos_y, pos_z
	input  logic [0:0]           m_axis_tuser,  // saturated
	output int                   errors,
	output int                   outstanding,
	output int                   results_seen,
	output int                   sat_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CNT_BITS-1:0] idx;
		word_t               x;
		word_t               y;
		word_t               z;
		logic                sat;
	} lorenz_state_t;

	// Model copy of the coefficients and the integrator state.
	word_t               sigma_m, rho_m, beta_m;
	logic [H_BITS-1:0]   h_m;
	logic [H2_BITS-1:0]  h2_m;
	logic [H6_BITS-1:0]  h6_m;
	word_t               x_m, y_m, z_m;
	logic [CNT_BITS-1:0] count_m;
	logic                clipped;
	lorenz_state_t       state_q[$];

	// Saturating add on words; the sum of two words always fits in 64 bits.
	function automatic word_t sat_add(input word_t a, input word_t b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > longint'(WORD_MAX)) begin
			clipped = 1'b1;
			return WORD_MAX;
		end
		if (s < longint'(WORD_MIN)) begin
			clipped = 1'b1;
			return WORD_MIN;
		end
		return word_t'(s);
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		longint s;
		s = longint'(a) - longint'(b);
		if (s > longint'(WORD_MAX)) begin
			clipped = 1'b1;
			return WORD_MAX;
		end
		if (s < longint'(WORD_MIN)) begin
			clipped = 1'b1;
			return WORD_MIN;
		end
		return word_t'(s);
	endfunction

	// Fixed-point product, rounded to nearest with ties to even, saturating.
	function automatic word_t sat_mul(input word_t a, input word_t b);
		logic          neg;
		logic [63:0]   ma, mb;
		logic [127:0]  prod, q, lim;
		logic [31:0]   rem;
		neg  = a[WORD_BITS-1] ^ b[WORD_BITS-1];
		ma   = a[WORD_BITS-1] ? 64'(-longint'(a)) : 64'(longint'(a));
		mb   = b[WORD_BITS-1] ? 64'(-longint'(b)) : 64'(longint'(b));
		prod = 128'(ma) * 128'(mb);
		q    = prod >> FRAC_BITS;
		rem  = prod[FRAC_BITS-1:0];
		if (rem > 32'h8000_0000 || (rem == 32'h8000_0000 && q[0]))
			q = q + 1;
		lim = neg ? (128'd1 << (WORD_BITS-1)) : 128'(WORD_MAX);
		if (q > lim) begin
			clipped = 1'b1;
			return neg ? WORD_MIN : WORD_MAX;
		end
		return neg ? word_t'(-q[63:0]) : word_t'(q[63:0]);
	endfunction

	// Lorenz derivatives at one point.
	function automatic void slopes(input word_t x, input word_t y, input word_t z,
			output word_t dx, output word_t dy, output word_t dz);
		dx = sat_mul(sigma_m, sat_sub(y, x));
		dy = sat_sub(sat_mul(x, sat_sub(rho_m, z)), y);
		dz = sat_sub(sat_mul(x, y), sat_mul(beta_m, z));
	endfunction

	function automatic word_t blend(input word_t s, input word_t k1, input word_t k2,
			input word_t k3, input word_t k4);
		word_t t;
		t = sat_add(k1, sat_add(k2, k2));
		t = sat_add(t, sat_add(k3, k3));
		t = sat_add(t, k4);
		return sat_add(s, sat_mul(word_t'(h6_m), t));
	endfunction

	// Advance the model by one beat and return the expected result.
	function automatic lorenz_state_t advance(input logic restart, input logic [143:0] init);
		word_t h, h2, k1x, k1y, k1z, k2x, k2y, k2z, k3x, k3y, k3z, k4x, k4y, k4z;
		lorenz_state_t r;
		clipped = 1'b0;
		h  = word_t'(h_m);
		h2 = word_t'(h2_m);
		if (restart) begin
			x_m     = init[47:0];
			y_m     = init[95:48];
			z_m     = init[143:96];
			count_m = '0;
		end else begin
			slopes(x_m, y_m, z_m, k1x, k1y, k1z);
			slopes(sat_add(x_m, sat_mul(h2, k1x)), sat_add(y_m, sat_mul(h2, k1y)),
				sat_add(z_m, sat_mul(h2, k1z)), k2x, k2y, k2z);
			slopes(sat_add(x_m, sat_mul(h2, k2x)), sat_add(y_m, sat_mul(h2, k2y)),
				sat_add(z_m, sat_mul(h2, k2z)), k3x, k3y, k3z);
			slopes(sat_add(x_m, sat_mul(h, k3x)), sat_add(y_m, sat_mul(h, k3y)),
				sat_add(z_m, sat_mul(h, k3z)), k4x, k4y, k4z);
			x_m     = blend(x_m, k1x, k2x, k3x, k4x);
			y_m     = blend(y_m, k1y, k2y, k3y, k4y);
			z_m     = blend(z_m, k1z, k2z, k3z, k4z);
			count_m = count_m + 1'b1;
		end
		r.idx = count_m;
		r.x   = x_m;
		r.y   = y_m;
		r.z   = z_m;
		r.sat = clipped;
		return r;
	endfunction

	// Follow register writes, predict on input beats, compare on output beats.
	always @(posedge clk or negedge arst_n) begin
		lorenz_state_t exp_r, got;
		if (!arst_n) begin
			sigma_m      = SIGMA_RST;
			rho_m        = RHO_RST;
			beta_m       = BETA_RST;
			h_m          = H_RST;
			h2_m         = H2_RST;
			h6_m         = H6_RST;
			x_m          = '0;
			y_m          = WORD_ONE;
			z_m          = WORD_ONE;
			count_m      = '0;
			errors       = 0;
			results_seen = 0;
			sat_results  = 0;
			state_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SIGMA: sigma_m = cfg_wdata;
					CFG_RHO:   rho_m   = cfg_wdata;
					CFG_BETA:  beta_m  = cfg_wdata;
					CFG_STEP:  h_m     = cfg_wdata[H_BITS-1:0];
					CFG_HALF:  h2_m    = cfg_wdata[H2_BITS-1:0];
					CFG_SIXTH: h6_m    = cfg_wdata[H6_BITS-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				state_q.push_back(advance(s_axis_tuser[0], s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.idx = m_axis_tdata[31:0];
				got.x   = m_axis_tdata[79:32];
				got.y   = m_axis_tdata[127:80];
				got.z   = m_axis_tdata[175:128];
				got.sat = m_axis_tuser[0];
				results_seen++;
				if (got.sat)
					sat_results++;
				if (state_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat idx=%0d x=%h y=%h z=%h sat=%b",
						$realtime, got.idx, got.x, got.y, got.z, got.sat);
				end else begin
					exp_r = state_q.pop_front();
					if (got.idx !== exp_r.idx) begin
						errors++;
						$display("%0t: step_index expected %0d actual %0d",
							$realtime, exp_r.idx, got.idx);
					end
					if (got.x !== exp_r.x) begin
						errors++;
						$display("%0t: pos_x expected %h actual %h", $realtime, exp_r.x, got.x);
					end
					if (got.y !== exp_r.y) begin
						errors++;
						$display("%0t: pos_y expected %h actual %h", $realtime, exp_r.y, got.y);
					end
					if (got.z !== exp_r.z) begin
						errors++;
						$display("%0t: pos_z expected %h actual %h", $realtime, exp_r.z, got.z);
					end
					if (got.sat !== exp_r.sat) begin
						errors++;
						$display("%0t: saturated expected %b actual %b",
							$realtime, exp_r.sat, got.sat);
					end
				end
			end
		end
		outstanding = state_q.size();
	end

endmodule

### bench/testbench.sv
// Top of the Lorenz RK4 integrator bench: clock, reset, register phases and stream traffic.
// Depends on lr4_pkg, lorenz_rk4_integrator and lorenz_checker, which checks every result.
module testbench;
	import lr4_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE      = 500;
	localparam int HOLD_CYCLES = 3000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_BITS-1:0]  cfg_index;
	logic [WORD_BITS-1:0] cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [143:0]         s_axis_tdata;  // init_x, init_y, init_z
	logic [0:0]           s_axis_tuser;  // cmd
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [175:0]         m_axis_tdata;  // step_index, pos_x, pos_y, pos_z
	logic [0:0]           m_axis_tuser;  // saturated

	int errors, outstanding, results_seen, sat_results;
	int cycles;
	int restarts_sent, steps_sent;
	bit calm;       // no idling on either side
	bit hold_req;   // ask the sink for one long stall

	lorenz_rk4_integrator u_dut (.*);

	lorenz_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Cycle count and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sink side: random stalls, one long hold-off on request.
	always @(posedge clk) begin
		int left;
		if (hold_req) begin
			m_axis_tready <= 1'b0;
			for (left = HOLD_CYCLES; left > 1; left--)
				@(posedge clk);
			hold_req <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(99) >= 37);
		end
	end

	// Offer one beat, with random gaps before it, and wait until it is taken.
	task automatic send_beat(input logic restart, input word_t ix, input word_t iy, input word_t iz);
		while (!calm && $urandom_range(99) < 37) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= restart;
		s_axis_tdata  <= {iz, iy, ix};
		do
			@(negedge clk);
		while (!s_axis_tready);
		@(posedge clk);
		if (restart)
			restarts_sent++;
		else
			steps_sent++;
	endtask

	// Drain all results, let the block settle, then write one register.
	task automatic write_reg(input cfg_idx_t idx, input logic [WORD_BITS-1:0] value);
		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic load_coefs(input word_t sg, input word_t rh, input word_t bt,
			input logic [H_BITS-1:0] h, input logic [H2_BITS-1:0] h2,
			input logic [H6_BITS-1:0] h6);
		write_reg(CFG_SIGMA, sg);
		write_reg(CFG_RHO, rh);
		write_reg(CFG_BETA, bt);
		write_reg(CFG_STEP, WORD_BITS'(h));
		write_reg(CFG_HALF, WORD_BITS'(h2));
		write_reg(CFG_SIXTH, WORD_BITS'(h6));
	endtask

	function automatic word_t any_word();
		return word_t'({$urandom, $urandom});
	endfunction

	// A value near the attractor: about +-64 with random fraction bits.
	function automatic word_t near_word();
		return word_t'($signed({$urandom, $urandom}) >>> 25);
	endfunction

	function automatic logic [H_BITS-1:0] any_step();
		logic [H_BITS-1:0] h;
		h = {1'($urandom_range(1)), $urandom};
		return (h > 33'h1_0000_0000) ? 33'h1_0000_0000 : h;
	endfunction

	// Mostly a restart near the attractor followed by a run of steps; some noise.
	task automatic random_traffic(input int beats);
		int n, run, k;
		n = 0;
		while (n < beats) begin
			if ($urandom_range(9) == 0)
				send_beat(1'b1, any_word(), any_word(), any_word());
			else
				send_beat(1'b1, near_word(), near_word(), near_word());
			run = $urandom_range(30, 5);
			for (k = 0; k < run; k++)
				send_beat(1'b0, any_word(), any_word(), any_word());
			n += run + 1;
		end
	endtask

	initial begin
		int p;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		cycles        = 0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		restarts_sent = 0;
		steps_sent    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: steps from the reset state, extremes, zeros, saturation.
		send_beat(1'b0, '0, '0, '0);
		send_beat(1'b0, WORD_MAX, WORD_MIN, '1);
		send_beat(1'b1, WORD_ONE, WORD_ONE, WORD_ONE);
		repeat (3) send_beat(1'b0, '0, '0, '0);
		send_beat(1'b1, WORD_MAX, WORD_MIN, '0);
		send_beat(1'b0, '0, '0, '0);
		send_beat(1'b0, '0, '0, '0);
		send_beat(1'b1, WORD_MIN, WORD_MAX, WORD_MAX);
		send_beat(1'b0, '0, '0, '0);
		send_beat(1'b1, '0, '0, '0);
		send_beat(1'b0, '1, '1, '1);
		send_beat(1'b1, '1, '1, '1);
		send_beat(1'b0, '0, '0, '0);
		send_beat(1'b1, WORD_MAX, WORD_MAX, WORD_MAX);
		send_beat(1'b0, '0, '0, '0);
		send_beat(1'b1, WORD_MIN, WORD_MIN, WORD_MIN);
		send_beat(1'b0, '0, '0, '0);

		// Fill the block while the sink holds off.
		hold_req <= 1'b1;
		@(posedge clk);
		random_traffic(12);

		// Extreme coefficients.
		load_coefs(WORD_MAX, WORD_MIN, WORD_MAX, 33'h1_0000_0000, 32'h8000_0000, 30'h3FFF_FFFF);
		send_beat(1'b1, WORD_ONE, WORD_ONE, WORD_ONE);
		random_traffic(60);
		load_coefs(WORD_MIN, WORD_MAX, WORD_MIN, '0, '0, '0);
		random_traffic(40);

		// Random coefficient sets and one reset set, with one calm phase.
		for (p = 0; p < 6; p++) begin
			if (p == 2)
				load_coefs(SIGMA_RST, RHO_RST, BETA_RST, H_RST, H2_RST, H6_RST);
			else
				load_coefs(near_word(), near_word(), any_word(), any_step(), $urandom,
					30'($urandom));
			calm = (p == 3);
			random_traffic(150);
		end
		calm = 1'b0;
		load_coefs(SIGMA_RST, RHO_RST, BETA_RST, H_RST, H2_RST, H6_RST);
		random_traffic(100);

		// Wait for the last results, then a little longer.
		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d restarts and %0d steps over several coefficient sets;",
			restarts_sent, steps_sent);
		$display("checked %0d results, %0d of them saturated.", results_seen, sat_results);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
